[hw/rtl/lst_pkg.sv]
// ----------------------------------------------------------------------------
// lst_pkg
// Types and constants shared by the lap and sector timer.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int NUM_SECTORS = 3;

  localparam logic [1:0] SECTOR_NONE = 2'd3;
  localparam logic [1:0] LAST_SECTOR = 2'(NUM_SECTORS - 1);
  localparam logic [2:0] SECTOR_LIMIT = 3'(NUM_SECTORS);

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;
  localparam logic [15:0] LAPS_MAX = 16'hFFFF;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_TRACK_LOADED = 2'd0;
  localparam logic [1:0] REG_TRACK_LENGTH = 2'd1;
  localparam logic [1:0] REG_MIN_SPEED    = 2'd2;

  localparam logic [17:0] MIN_SPEED_RESET = 18'd1000;

  typedef struct packed {
    logic        track_loaded;
    logic [23:0] track_length_mm;
    logic [17:0] min_lap_speed_mm_s;
  } cfg_t;

  // first field in the highest bits
  typedef struct packed {
    logic [1:0]         sector_here;
    logic [19:0]        tick_us;
    logic signed [18:0] speed_mm_s;
    logic [23:0]        position_mm;
  } in_item_t;

  typedef struct packed {
    logic        done_sector_is_best;
    logic [31:0] done_sector_us;
    logic [1:0]  done_sector_index;
    logic        sector_done;
    logic        lap_done;
    logic        best_lap_valid;
    logic [31:0] best_lap_us;
    logic [31:0] last_lap_us;
    logic [31:0] current_lap_us;
    logic [1:0]  current_sector;
    logic [15:0] lap_total;
  } result_t;

endpackage

[hw/rtl/lst_core.sv]
// ----------------------------------------------------------------------------
// lst_core
// Timing state and the combinational update for one tick item.
// ----------------------------------------------------------------------------
module lst_core (
  input  logic              clk,
  input  logic              rst_n,
  input  lst_pkg::cfg_t     cfg,
  input  logic              in_fire,
  input  lst_pkg::in_item_t in_item,
  output lst_pkg::result_t  res
);

  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] lap_r, lap_nxt;
  logic [31:0] last_lap_r, last_lap_nxt;
  logic [31:0] best_lap_r, best_lap_nxt;
  logic        best_lap_seen_r, best_lap_seen_nxt;
  logic [31:0] best_sec_r [lst_pkg::NUM_SECTORS];
  logic [31:0] best_sec_nxt [lst_pkg::NUM_SECTORS];
  logic        best_sec_seen_r [lst_pkg::NUM_SECTORS];
  logic        best_sec_seen_nxt [lst_pkg::NUM_SECTORS];
  logic [15:0] laps_r, laps_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [23:0] prev_pos_r, prev_pos_nxt;

  logic [32:0]        elapsed_sum, lap_sum;
  logic [31:0]        elapsed_sat, lap_sat;
  logic signed [26:0] wrap_sum;
  logic               speed_fast;
  logic               held_ok;
  logic [31:0]        sec_t;
  logic               sec_is_best;
  logic [1:0]         sec_new;
  logic               fwd;
  logic               rec;

  always_comb begin
    elapsed_sum = {1'b0, elapsed_r} + {13'd0, in_item.tick_us};
    lap_sum     = {1'b0, lap_r} + {13'd0, in_item.tick_us};
    elapsed_sat = elapsed_sum[32] ? lst_pkg::TIME_MAX : elapsed_sum[31:0];
    lap_sat     = lap_sum[32] ? lst_pkg::TIME_MAX : lap_sum[31:0];

    // 2*(pos - prev) < -len  <=>  2*pos - 2*prev + len < 0
    wrap_sum = $signed({2'b00, in_item.position_mm, 1'b0})
             - $signed({2'b00, prev_pos_r, 1'b0})
             + $signed({3'b000, cfg.track_length_mm});
    speed_fast = $signed({in_item.speed_mm_s[18], in_item.speed_mm_s})
               > $signed({2'b00, cfg.min_lap_speed_mm_s});

    held_ok = {1'b0, held_r} < lst_pkg::SECTOR_LIMIT;
    sec_t   = elapsed_sat - start_r;
    sec_is_best = held_ok && (!best_sec_seen_r[held_r] || sec_t < best_sec_r[held_r]);

    sec_new = ({1'b0, in_item.sector_here} < lst_pkg::SECTOR_LIMIT) ?
              in_item.sector_here : lst_pkg::SECTOR_NONE;
    fwd = 1'b0;
    if (sec_new != held_r && sec_new != lst_pkg::SECTOR_NONE) begin
      if (!held_ok && sec_new == 2'd0) fwd = 1'b1;
      if (held_ok && sec_new == held_r + 2'd1) fwd = 1'b1;
      if (held_r == lst_pkg::LAST_SECTOR && sec_new == 2'd0) fwd = 1'b1;
    end

    elapsed_nxt       = elapsed_r;
    start_nxt         = start_r;
    lap_nxt           = lap_r;
    last_lap_nxt      = last_lap_r;
    best_lap_nxt      = best_lap_r;
    best_lap_seen_nxt = best_lap_seen_r;
    best_sec_nxt      = best_sec_r;
    best_sec_seen_nxt = best_sec_seen_r;
    laps_nxt          = laps_r;
    held_nxt          = held_r;
    prev_pos_nxt      = prev_pos_r;
    rec               = 1'b0;

    res.lap_done = 1'b0;

    if (cfg.track_loaded) begin
      elapsed_nxt = elapsed_sat;
      lap_nxt     = lap_sat;
      if (cfg.track_length_mm != 24'd0) begin
        if (speed_fast && wrap_sum[26]) begin
          rec          = held_ok;
          last_lap_nxt = lap_sat;
          if (!best_lap_seen_r || lap_sat < best_lap_r) begin
            best_lap_nxt      = lap_sat;
            best_lap_seen_nxt = 1'b1;
          end
          if (laps_r != lst_pkg::LAPS_MAX) laps_nxt = laps_r + 16'd1;
          res.lap_done = 1'b1;
          lap_nxt      = '0;
          held_nxt     = 2'd0;
          start_nxt    = elapsed_sat;
        end else begin
          if (fwd) begin
            rec       = held_ok;
            start_nxt = elapsed_sat;
          end
          held_nxt = sec_new;
        end
        prev_pos_nxt = in_item.position_mm;
      end
    end

    if (rec && sec_is_best) begin
      best_sec_nxt[held_r]      = sec_t;
      best_sec_seen_nxt[held_r] = 1'b1;
    end

    res.lap_total           = laps_nxt;
    res.current_sector      = held_nxt;
    res.current_lap_us      = lap_nxt;
    res.last_lap_us         = last_lap_nxt;
    res.best_lap_us         = best_lap_nxt;
    res.best_lap_valid      = best_lap_seen_nxt;
    res.sector_done         = rec;
    res.done_sector_index   = rec ? held_r : 2'd0;
    res.done_sector_us      = rec ? sec_t : 32'd0;
    res.done_sector_is_best = rec && sec_is_best;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r       <= '0;
      start_r         <= '0;
      lap_r           <= '0;
      last_lap_r      <= '0;
      best_lap_r      <= '0;
      best_lap_seen_r <= 1'b0;
      for (int i = 0; i < lst_pkg::NUM_SECTORS; i++) begin
        best_sec_r[i]      <= '0;
        best_sec_seen_r[i] <= 1'b0;
      end
      laps_r     <= '0;
      held_r     <= '0;
      prev_pos_r <= '0;
    end else if (in_fire) begin
      elapsed_r       <= elapsed_nxt;
      start_r         <= start_nxt;
      lap_r           <= lap_nxt;
      last_lap_r      <= last_lap_nxt;
      best_lap_r      <= best_lap_nxt;
      best_lap_seen_r <= best_lap_seen_nxt;
      best_sec_r      <= best_sec_nxt;
      best_sec_seen_r <= best_sec_seen_nxt;
      laps_r          <= laps_nxt;
      held_r          <= held_nxt;
      prev_pos_r      <= prev_pos_nxt;
    end
  end

endmodule

[hw/rtl/lap_sector_timer_unit.sv]
// ----------------------------------------------------------------------------
// lap_sector_timer_unit
// Lap and sector timer: tick items in, one timing result item out per tick.
// ----------------------------------------------------------------------------
//  port group | direction | payload
//  in_*       | sink      | tdata: position_mm, speed_mm_s, tick_us, sector_here
//  out_*      | source    | tdata: lap and sector timing result
//  cfg_*      | APB slave | track_loaded, track_length_mm, min_lap_speed_mm_s
//
//  One item per cycle while in_tready is high; state updates in the accept
//  cycle; the result is registered in the output register or the skid entry.
//  A two-entry output stage (output register + skid) keeps in_tready high
//  while one result waits; in_tready drops only when both are full.
//  Reset is synchronous; state clears to zero, min_lap_speed_mm_s to 1000.
// ----------------------------------------------------------------------------
module lap_sector_timer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [23:0] position_mm, [42:24] speed_mm_s, [62:43] tick_us, [64:63] sector_here
  input  logic [71:0]   in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [15:0] lap_total, [17:16] current_sector, [49:18] current_lap_us,
  // [81:50] last_lap_us, [113:82] best_lap_us, [114] best_lap_valid,
  // [115] lap_done, [116] sector_done, [118:117] done_sector_index,
  // [150:119] done_sector_us, [151] done_sector_is_best
  output logic [151:0]  out_tdata,
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [3:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);

  lst_pkg::cfg_t     cfg_r;
  lst_pkg::in_item_t in_item;
  lst_pkg::result_t  res;
  lst_pkg::result_t  out_r, out_nxt, skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic              in_fire, cfg_wr;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_loaded       <= 1'b0;
      cfg_r.track_length_mm    <= '0;
      cfg_r.min_lap_speed_mm_s <= lst_pkg::MIN_SPEED_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        lst_pkg::REG_TRACK_LOADED: cfg_r.track_loaded       <= cfg_pwdata[0];
        lst_pkg::REG_TRACK_LENGTH: cfg_r.track_length_mm    <= cfg_pwdata[23:0];
        lst_pkg::REG_MIN_SPEED:    cfg_r.min_lap_speed_mm_s <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      lst_pkg::REG_TRACK_LOADED: cfg_prdata = {31'd0, cfg_r.track_loaded};
      lst_pkg::REG_TRACK_LENGTH: cfg_prdata = {8'd0, cfg_r.track_length_mm};
      lst_pkg::REG_MIN_SPEED:    cfg_prdata = {14'd0, cfg_r.min_lap_speed_mm_s};
      default:                   cfg_prdata = '0;
    endcase
  end

  // timing core
  assign in_item   = lst_pkg::in_item_t'(in_tdata[64:0]);
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  lst_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_item (in_item),
    .res     (res)
  );

  // output register with skid entry
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = in_fire;
      end else begin
        out_nxt       = res;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

[hw/rtl/lst_checker.sv]
// ----------------------------------------------------------------------------
// lst_checker
// Port-level checks for the lap and sector timer, bound to the top level.
// ----------------------------------------------------------------------------
module lst_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata
);

  // a waiting result item is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item dropped or changed while stalled");

  // no sector fields without a recorded sector
  a_sector_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[116] |->
      out_tdata[118:117] == 2'd0 && out_tdata[150:119] == 32'd0 && !out_tdata[151])
    else $error("sector fields set without sector_done");

  // a completed lap restarts timing at sector 0 and leaves a valid best lap
  a_lap_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[115] |->
      out_tdata[49:18] == 32'd0 && out_tdata[17:16] == 2'd0 && out_tdata[114]
      && out_tdata[113:82] <= out_tdata[81:50])
    else $error("lap completion left inconsistent lap state");

  // a recorded sector never points at the none code
  a_sector_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[116] |-> out_tdata[118:117] != lst_pkg::SECTOR_NONE)
    else $error("sector recorded for no sector");

endmodule

bind lap_sector_timer_unit lst_checker u_lst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
